### rtl/core/rbsa_pkg.sv
// Package with shared constants, types and codes of the ring buffer space allocator.
`timescale 1ns / 1ps
package rbsa_pkg;
  localparam int MAX_RECORDS_DEF = 16;
  localparam int OFFSET_BITS_DEF = 20;
  localparam int REQ_W = 21;
  localparam int ALIGN_W = 13;
  localparam int CFG_W = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_BASE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE = 1'd1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_BAD     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIT,
    S_PLACE,
    S_SEARCH,
    S_RETIRE,
    S_DONE
  } state_t;
endpackage

### rtl/core/rbsa_if.sv
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps
interface rbsa_req_if #(parameter int OB = 20);
  logic          valid;
  logic          ready;
  logic          operation;
  logic [20:0]   request_bytes;
  logic [12:0]   align_bytes;
  logic [OB-1:0] release_offset;
  modport source (output valid, operation, request_bytes, align_bytes, release_offset,
                  input ready);
  modport sink (input valid, operation, request_bytes, align_bytes, release_offset,
                output ready);
endinterface

interface rbsa_res_if #(parameter int OB = 20);
  logic          valid;
  logic          ready;
  logic [1:0]    status;
  logic [OB-1:0] granted_offset;
  modport source (output valid, status, granted_offset, input ready);
  modport sink (input valid, status, granted_offset, output ready);
endinterface

### rtl/core/rbsa_cell.sv
// One cell of the record ring: holds a record and shifts it toward the front.
`timescale 1ns / 1ps
module rbsa_cell import rbsa_pkg::*; #(
  parameter int OB = OFFSET_BITS_DEF
) (
  input  logic          clk,
  input  logic          load,
  input  logic [OB-1:0] load_start,
  input  logic [REQ_W-1:0] load_len,
  input  logic          load_pend,
  input  logic          shift,
  input  logic [OB-1:0] nb_start,
  input  logic [REQ_W-1:0] nb_len,
  input  logic          nb_pend,
  input  logic          mark,
  output logic [OB-1:0] start,
  output logic [REQ_W-1:0] len,
  output logic          pend
);
  // Load has priority, then the rotation, then a pending mark.
  always_ff @(posedge clk) begin
    if (load) begin
      start <= load_start;
      len   <= load_len;
      pend  <= load_pend;
    end else if (shift) begin
      start <= nb_start;
      len   <= nb_len;
      pend  <= nb_pend | mark;
    end else if (mark) begin
      pend <= 1'b1;
    end
  end
endmodule

### rtl/core/ring_buffer_space_allocator_top.sv
// Top level of the ring buffer space allocator.
//  channel | dir | handshake    | payload
//  req     | in  | valid/ready  | operation, request_bytes, align_bytes, release_offset
//  res     | out | valid/ready  | status, granted_offset
//  cfg     | in  | cfg_we       | cfg_index, cfg_data
// Records sit in a row of cells that rotates by one position a cycle during search and
// retire; cell 0 is the front. An allocate steps through accept, alignment, placement
// and result. A free rotates the whole row once in search and, on a match, then retires
// the pending front records before the result.
// Reset clears head, tail and count; record contents are not cleared.
// One item is in work at a time; the result register waits for res.ready.
`timescale 1ns / 1ps
module ring_buffer_space_allocator_top import rbsa_pkg::*; #(
  parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  rbsa_req_if.sink             req,
  rbsa_res_if.source           res
);
  localparam int OB = OFFSET_BITS_DEF;
  localparam int N = MAX_RECORDS;
  localparam int CW = $clog2(N + 1);
  localparam int RW = $clog2(N);
  localparam int EW = OB + 2;

  logic [31:0] region_base;
  logic [20:0] region_size;
  logic [OB:0] eff;

  state_t state, state_next;
  logic [OB-1:0] head, tail;
  logic [CW-1:0] count;
  logic [RW:0]   rot;
  logic          op;
  logic [REQ_W-1:0] rq;
  logic [ALIGN_W-1:0] al;
  logic [OB-1:0] rel;
  logic          found;
  logic [1:0]    st;
  logic [OB-1:0] got;

  logic [OB-1:0]    c_start [N];
  logic [REQ_W-1:0] c_len [N];
  logic             c_pend [N];
  logic             c_load [N];
  logic [OB-1:0]    c_lstart [N];
  logic [REQ_W-1:0] c_llen [N];
  logic             c_lpend [N];
  logic             c_mark [N];
  logic             shift;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      region_base <= '0;
      region_size <= 21'd1048576;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE: region_base <= cfg_data;
        REG_SIZE: region_size <= cfg_data[20:0];
        default: ;
      endcase
    end
  end

  localparam logic [21:0] CAP = 22'(1) << OB;
  assign eff = ({1'b0, region_size} > CAP) ? CAP[OB:0] : region_size[OB:0];

  // Fit of the request into a range [lo, hi), wide enough to carry overflow.
  function automatic logic [EW:0] fit_off(input logic [EW-1:0] lo, input logic [31:0] base,
                                          input logic [ALIGN_W-1:0] a);
    logic [33:0] abs_lo, am, alg;
    abs_lo = {2'b0, base} + 34'(lo);
    am = 34'(a) - 34'd1;
    alg = (a != '0) ? ((abs_lo + am) & ~am) : abs_lo;
    return (EW + 1)'(alg - {2'b0, base});
  endfunction

  function automatic logic fits(input logic [EW-1:0] lo, input logic [EW-1:0] hi,
                                input logic [EW:0] off, input logic [REQ_W-1:0] r);
    logic [EW:0] hh;
    hh = {1'b0, hi};
    return !({1'b0, lo} > hh || off > hh || (hh - off) < (EW + 1)'(r));
  endfunction

  // Range candidates for the allocate cases; the aligned offsets are registered.
  logic [EW-1:0] lo_a, hi_a, lo_b, hi_b;
  logic [EW:0]   off_a, off_b;
  logic          fit_a, fit_b;
  logic [CW-1:0] room;
  always_comb begin
    lo_a = (count == '0) ? '0 : EW'(head);
    hi_a = (count == '0 || head > tail) ? EW'(eff) : EW'(tail);
    lo_b = '0;
    hi_b = EW'(tail);
    fit_a = fits(lo_a, hi_a, off_a, rq);
    fit_b = (count != '0) && (head > tail) && fits(lo_b, hi_b, off_b, rq);
    room = CW'(N) - count;
  end

  function automatic logic [OB-1:0] wrap_end(input logic [EW:0] v, input logic [OB:0] sz);
    logic [EW:0] w;
    w = (v >= (EW + 1)'(sz)) ? v - (EW + 1)'(sz) : v;
    return w[OB-1:0];
  endfunction

  logic bad;
  assign bad = (rq == '0) || ((al & (al - 1'b1)) != '0);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (req.valid) state_next = S_FIT;
      S_FIT:    state_next = op ? S_SEARCH : S_PLACE;
      S_PLACE:  state_next = S_DONE;
      S_SEARCH: if (rot == (RW + 1)'(N)) state_next = found ? S_RETIRE : S_DONE;
      S_RETIRE: if (count == '0 || !c_pend[0]) state_next = S_DONE;
      S_DONE:   if (res.ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    req.ready = (state == S_IDLE);
    res.valid = (state == S_DONE);
    res.status = st;
    res.granted_offset = got;
  end

  // Rotation during the search walks every cell once; during retire cell 0 leaves.
  logic sea_hit;
  assign sea_hit = (state == S_SEARCH) && (rot < (RW + 1)'(N)) && !found &&
                   (RW + 1)'(count) > rot && !c_pend[0] && c_start[0] == rel;
  assign shift = (state == S_SEARCH && rot < (RW + 1)'(N)) ||
                 (state == S_RETIRE && count != '0 && c_pend[0]);

  // Cell load controls: new records enter at slot count (or count+1) of the row.
  logic push1, push2;
  logic [OB-1:0] pad_start, blk_start;
  logic [REQ_W-1:0] pad_len;
  always_comb begin
    push1 = 1'b0;
    push2 = 1'b0;
    pad_start = head;
    pad_len = REQ_W'(eff) - REQ_W'(head);
    blk_start = fit_a ? off_a[OB-1:0] : off_b[OB-1:0];
    if (state == S_PLACE && !op && !bad && room != '0 &&
        !(count != '0 && head == tail)) begin
      if (fit_a) push1 = 1'b1;
      else if (fit_b && room >= CW'(2)) push2 = 1'b1;
    end
    for (int i = 0; i < N; i++) begin
      c_mark[i] = (i == N - 1) && sea_hit;
      c_load[i] = 1'b0;
      c_lstart[i] = blk_start;
      c_llen[i] = rq;
      c_lpend[i] = 1'b0;
      if (push1 && CW'(i) == count) c_load[i] = 1'b1;
      if (push2 && CW'(i) == count) begin
        c_load[i] = 1'b1;
        c_lstart[i] = pad_start;
        c_llen[i] = pad_len;
        c_lpend[i] = 1'b1;
      end
      if (push2 && CW'(i) == count + 1'b1) c_load[i] = 1'b1;
    end
  end

  // Row of cells; cell i takes the record of cell i+1, cell N-1 takes cell 0.
  for (genvar g = 0; g < N; g++) begin : g_cell
    localparam int NB = (g + 1) % N;
    rbsa_cell #(.OB(OB)) u_cell (
      .clk(clk), .load(c_load[g]), .load_start(c_lstart[g]), .load_len(c_llen[g]),
      .load_pend(c_lpend[g]), .shift(shift), .nb_start(c_start[NB]),
      .nb_len(c_len[NB]), .nb_pend(c_pend[NB]), .mark(c_mark[g]),
      .start(c_start[g]), .len(c_len[g]), .pend(c_pend[g])
    );
  end

  // Control registers and result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
      rot   <= '0;
      found <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: if (req.valid) begin
          op <= req.operation;
          rq <= req.request_bytes;
          al <= req.align_bytes;
          rel <= req.release_offset;
          rot <= '0;
          found <= 1'b0;
        end
        S_FIT: begin
          // Aligned start offsets of both candidate ranges.
          off_a <= fit_off(lo_a, region_base, al);
          off_b <= fit_off(lo_b, region_base, al);
          got <= '0;
          st <= ST_OK;
        end
        S_PLACE: begin
          if (bad) st <= ST_BAD;
          else if (push1) begin
            st <= ST_OK;
            got <= off_a[OB-1:0];
            head <= wrap_end(off_a + (EW + 1)'(rq), eff);
            if (count == '0) tail <= '0;
            count <= count + 1'b1;
          end else if (push2) begin
            st <= ST_OK;
            got <= off_b[OB-1:0];
            head <= OB'(off_b + (EW + 1)'(rq));
            count <= count + CW'(2);
          end else begin
            st <= ST_NOSPACE;
          end
        end
        S_SEARCH: begin
          if (rot < (RW + 1)'(N)) rot <= rot + 1'b1;
          if (sea_hit) found <= 1'b1;
          if (rot == (RW + 1)'(N) && !found) st <= ST_UNKNOWN;
        end
        S_RETIRE: if (count != '0 && c_pend[0]) begin
          tail <= wrap_end((EW + 1)'(c_start[0]) + (EW + 1)'(c_len[0]), eff);
          count <= count - 1'b1;
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count: assert property (@(posedge clk) disable iff (rst) count <= CW'(N))
    else $error("record count above capacity");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |=> res.valid && $stable(res.status))
    else $error("result changed while stalled");
  a_free_ok: assert property (@(posedge clk) disable iff (rst)
    state == S_RETIRE |-> found)
    else $error("retire without a match");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !req.ready)
    else $error("request taken while busy");
`endif
endmodule

### test/ring_buffer_space_allocator_top_tb.sv
// Self-checking testbench for the ring buffer space allocator top level.
`timescale 1ns / 1ps
module ring_buffer_space_allocator_top_tb;
  import rbsa_pkg::*;

  localparam int NREC = MAX_RECORDS_DEF;
  localparam int OB = OFFSET_BITS_DEF;
  localparam longint unsigned OMASK = (64'd1 << OB) - 1;
  localparam longint LIMIT = 3000000;

  typedef struct packed {
    logic            operation;
    logic [20:0]     request_bytes;
    logic [12:0]     align_bytes;
    logic [OB-1:0]   release_offset;
  } request_t;

  typedef struct packed {
    status_t         status;
    logic [OB-1:0]   granted_offset;
  } grant_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  rbsa_req_if #(.OB(OB)) req ();
  rbsa_res_if #(.OB(OB)) res ();

  ring_buffer_space_allocator_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req), .res(res)
  );

  request_t pending_requests[$];
  grant_t expected_grants[$];
  longint unsigned live_offsets[$];
  int errors = 0;
  int grants_seen = 0;
  int wraps_seen = 0;
  int idle_mode = 0;
  longint cycles = 0;

  // Shadow copy of the allocator state.
  longint unsigned sh_base, sh_size, sh_head, sh_tail;
  longint unsigned sh_start[NREC];
  longint unsigned sh_len[NREC];
  bit sh_pend[NREC];
  int sh_front, sh_count;

  function automatic bit fits(longint unsigned lo, longint unsigned hi, longint unsigned rq,
                              longint unsigned al, output longint unsigned got);
    longint unsigned abs_lo, aligned, off;
    abs_lo = sh_base + lo;
    aligned = (al != 0) ? ((abs_lo + al - 1) & ~(al - 1)) : abs_lo;
    off = aligned - sh_base;
    got = 0;
    if (lo > hi || off > hi) return 0;
    if (hi - off < rq) return 0;
    got = off;
    return 1;
  endfunction

  function automatic longint unsigned wrap_at(longint unsigned v, longint unsigned s);
    if (v >= s) v -= s;
    return v & OMASK;
  endfunction

  function automatic void push_rec(longint unsigned st, longint unsigned ln, bit p);
    int s;
    s = (sh_front + sh_count) % NREC;
    sh_start[s] = st & OMASK;
    sh_len[s] = ln & 64'h1FFFFF;
    sh_pend[s] = p;
    sh_count++;
  endfunction

  function automatic status_t allocate(longint unsigned rq, longint unsigned al,
                                       output longint unsigned got);
    longint unsigned sz, off;
    int room;
    sz = (sh_size > (64'd1 << OB)) ? (64'd1 << OB) : sh_size;
    room = NREC - sh_count;
    got = 0;
    if (rq == 0 || (al & (al - 1)) != 0) return ST_BAD;
    if (room == 0) return ST_NOSPACE;
    if (sh_count == 0) begin
      sh_head = 0;
      sh_tail = 0;
      if (!fits(0, sz, rq, al, off)) return ST_NOSPACE;
      sh_head = wrap_at(off + rq, sz);
      push_rec(off, rq, 0);
    end else if (sh_head == sh_tail) begin
      return ST_NOSPACE;
    end else if (sh_head > sh_tail) begin
      if (fits(sh_head, sz, rq, al, off)) begin
        sh_head = wrap_at(off + rq, sz);
        push_rec(off, rq, 0);
      end else if (fits(0, sh_tail, rq, al, off)) begin
        if (room < 2) return ST_NOSPACE;
        push_rec(sh_head, sz - sh_head, 1);
        sh_head = (off + rq) & OMASK;
        push_rec(off, rq, 0);
        wraps_seen++;
      end else begin
        return ST_NOSPACE;
      end
    end else begin
      if (!fits(sh_head, sh_tail, rq, al, off)) return ST_NOSPACE;
      sh_head = wrap_at(off + rq, sz);
      push_rec(off, rq, 0);
    end
    got = off;
    return ST_OK;
  endfunction

  function automatic status_t release_block(longint unsigned rel);
    longint unsigned sz;
    int i, s, hit;
    sz = (sh_size > (64'd1 << OB)) ? (64'd1 << OB) : sh_size;
    hit = -1;
    for (i = 0; i < sh_count; i++) begin
      s = (sh_front + i) % NREC;
      if (hit < 0 && !sh_pend[s] && sh_start[s] == rel) hit = s;
    end
    if (hit < 0) return ST_UNKNOWN;
    sh_pend[hit] = 1;
    while (sh_count > 0 && sh_pend[sh_front]) begin
      sh_tail = wrap_at(sh_start[sh_front] + sh_len[sh_front], sz);
      sh_front = (sh_front + 1) % NREC;
      sh_count--;
    end
    return ST_OK;
  endfunction

  // Works out the grant for one accepted request and tracks live blocks.
  function automatic void predict_grant(request_t r);
    grant_t g;
    longint unsigned got;
    int k;
    got = 0;
    if (r.operation == 1'b0) begin
      g.status = allocate(r.request_bytes, r.align_bytes, got);
      if (g.status == ST_OK) live_offsets.insert(live_offsets.size(), got);
    end else begin
      g.status = release_block(r.release_offset);
      if (g.status == ST_OK) begin
        for (k = 0; k < live_offsets.size(); k++)
          if (live_offsets[k] == r.release_offset) begin
            live_offsets.delete(k);
            break;
          end
      end
    end
    g.granted_offset = (g.status == ST_OK) ? got[OB-1:0] : '0;
    expected_grants.insert(expected_grants.size(), g);
  endfunction

  // Clock, reset and known input values from time zero.
  initial begin
    clk = 0;
    rst = 1;
    cfg_we = 0;
    cfg_index = REG_BASE;
    cfg_data = '0;
    req.valid = 0;
    req.operation = 0;
    req.request_bytes = '0;
    req.align_bytes = '0;
    req.release_offset = '0;
    res.ready = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("%0t timeout with %0d grants outstanding", $time, expected_grants.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Request driver: predicts on acceptance, then offers the next request or idles.
  always @(posedge clk) begin
    request_t nxt;
    bit take;
    if (rst) begin
      req.valid <= 0;
    end else begin
      take = 1;
      if (req.valid && req.ready) begin
        predict_grant({req.operation, req.request_bytes, req.align_bytes, req.release_offset});
      end
      if (req.valid && !req.ready) begin
        take = 0;
      end else if ((idle_mode == 1 && $urandom_range(99) < 87) ||
                   (idle_mode == 3 && $urandom_range(99) < 14) ||
                   pending_requests.size() == 0) begin
        req.valid <= 0;
        take = 0;
      end
      if (take) begin
        nxt = pending_requests[0];
        pending_requests.delete(0);
        req.valid <= 1;
        req.operation <= nxt.operation;
        req.request_bytes <= nxt.request_bytes;
        req.align_bytes <= nxt.align_bytes;
        req.release_offset <= nxt.release_offset;
      end
    end
  end

  // Grant monitor with random back-pressure.
  always @(posedge clk) begin
    grant_t want;
    if (rst) begin
      res.ready <= 0;
    end else begin
      if (res.valid && res.ready) begin
        grants_seen++;
        if (expected_grants.size() == 0) begin
          $display("%0t unexpected grant: actual status %0d offset %h", $time,
                   res.status, res.granted_offset);
          errors++;
        end else begin
          want = expected_grants[0];
          expected_grants.delete(0);
          if (res.status !== want.status || res.granted_offset !== want.granted_offset) begin
            $display("%0t mismatch: expected status %0d offset %h, actual status %0d offset %h",
                     $time, want.status, want.granted_offset, res.status, res.granted_offset);
            errors++;
          end
        end
      end
      res.ready <= !((idle_mode == 2 && $urandom_range(99) < 87) ||
                     (idle_mode == 3 && $urandom_range(99) < 14));
    end
  end

  task automatic queue_request(bit op, logic [20:0] rq, logic [12:0] al, logic [OB-1:0] rel);
    request_t r;
    r = {op, rq, al, rel};
    while (pending_requests.size() > 1) @(posedge clk);
    pending_requests.insert(pending_requests.size(), r);
  endtask

  task automatic wait_drained();
    while (pending_requests.size() != 0 || req.valid || expected_grants.size() != 0)
      @(posedge clk);
  endtask

  // Register writes happen only with the block idle and every grant collected.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    wait_drained();
    repeat (40) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_BASE) sh_base = val;
    else sh_size = val & 32'h1FFFFF;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic random_request(int free_pct, longint unsigned span);
    logic [20:0] rq;
    logic [12:0] al;
    logic [OB-1:0] rel;
    int pick;
    pick = $urandom_range(99);
    if (pick < free_pct) begin
      if (live_offsets.size() != 0 && $urandom_range(9) < 8)
        rel = OB'(live_offsets[$urandom_range(live_offsets.size() - 1)]);
      else
        rel = OB'($urandom);
      queue_request(1, 21'($urandom), 13'($urandom), rel);
    end else begin
      case ($urandom_range(19))
        0: rq = 0;
        1: rq = 21'h100000;
        2: rq = 21'($urandom);
        default: rq = 21'($urandom_range(span > 1 ? span : 1, 1));
      endcase
      case ($urandom_range(9))
        0, 1, 2: al = 0;
        3: al = 13'($urandom);
        default: al = 13'd1 << $urandom_range(12);
      endcase
      queue_request(0, rq, al, OB'($urandom));
    end
  endtask

  initial begin
    logic [31:0] bases[6];
    logic [31:0] sizes[6];
    int p, n;
    bases = '{32'h0, 32'hFFFFFFFF, 32'h0000_0123, 32'h0, 32'h8000_0007, 32'h0};
    sizes = '{32'h100000, 32'd4096, 32'h1FFFFF, 32'd1, 32'd300, 32'd0};
    sh_base = 0;
    sh_size = 32'h100000;
    sh_head = 0;
    sh_tail = 0;
    sh_front = 0;
    sh_count = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed requests: bad sizes and alignments, whole region, unknown frees, wrap.
    queue_request(0, 0, 0, 0);
    queue_request(0, 16, 3, 0);
    queue_request(0, 21'h100000, 0, 0);
    queue_request(0, 1, 0, 0);
    queue_request(1, 0, 0, 0);
    queue_request(1, 0, 0, 0);
    queue_request(0, 21'h0FFF00, 4096, 0);
    queue_request(0, 500, 1, 0);
    queue_request(0, 100, 4096, 0);
    queue_request(1, 0, 0, 0);
    queue_request(1, 20'hFFFFF, 0, 0);
    wait_drained();
    queue_request(0, 21'h000200, 0, 0);
    queue_request(1, 0, 0, OB'(live_offsets.size() ? live_offsets[0] : 0));
    wait_drained();
    queue_request(0, 21'h000080, 2048, 0);
    queue_request(0, 21'h1FFFFF, 0, 0);
    queue_request(0, 7, 13'h1FFF, 0);
    wait_drained();

    for (p = 0; p < 6; p++) begin
      write_reg(REG_BASE, bases[p]);
      write_reg(REG_SIZE, sizes[p]);
      for (n = 0; n < 275; n++) begin
        idle_mode = (n / 70) % 4;
        if (n == 140) wait_drained();
        random_request(30 + $urandom_range(25),
                       sizes[p] > 32'h100000 ? 64'h8000 : (sizes[p] + 3) / 4);
      end
    end
    wait_drained();
    idle_mode = 0;
    repeat (60) @(posedge clk);
    $display("Checked %0d grants over six region settings, %0d wrapping allocations.",
             grants_seen, wraps_seen);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
